@@ src/hml_pkg.sv @@
`timescale 1ns / 1ps
package hml_pkg;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NOTFOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // wide enough for any bucket index up to 65536 buckets
  localparam int BUCKET_W = 16;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] key;
    logic [7:0]         insert_value;
  } req_t;

  typedef struct packed {
    logic [7:0] answer;
    logic [2:0] status;
  } rsp_t;

  typedef struct packed {
    logic                opcode;
    logic [31:0]         key;
    logic [7:0]          insert_value;
    logic [BUCKET_W-1:0] bucket;
  } job_t;

endpackage

@@ src/hml_front.sv @@
`timescale 1ns / 1ps
module hml_front #(
  parameter int BUCKETS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  hml_pkg::req_t req,
  output logic          job_valid,
  input  logic          job_space,
  output hml_pkg::job_t job
);
  import hml_pkg::*;

  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / BUCKETS);
  localparam logic [16:0] BMUL  = 17'(BUCKETS);
  localparam logic [30:0] BMOD  = 31'(BUCKETS);

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_MUL2, F_SEND} fstate_t;

  fstate_t     state;
  logic        op;
  logic [31:0] key;
  logic [7:0]  val;
  logic [30:0] folded;
  logic [63:0] prod;
  logic [30:0] qb;
  logic [30:0] rem_raw;
  logic [30:0] rem;
  logic        take;

  assign full      = !(state == F_IDLE || (state == F_SEND && job_space));
  assign take      = push && !full;
  assign job_valid = (state == F_SEND);

  // remainder estimate is below twice the bucket count: one correction
  assign rem_raw = folded - qb;
  assign rem     = (rem_raw >= BMOD) ? (rem_raw - BMOD) : rem_raw;

  // hold the word in the capture registers; bucket is settled in F_SEND
  assign job = '{opcode: op, key: key, insert_value: val, bucket: BUCKET_W'(rem)};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE, F_SEND: begin
          if (take) begin
            op     <= req.opcode;
            key    <= req.key;
            val    <= req.insert_value;
            folded <= req.key[31] ? ~req.key[30:0] : req.key[30:0];
            state  <= F_MUL;
          end else if (state == F_SEND && job_space) begin
            state <= F_IDLE;
          end
        end
        F_MUL: begin
          prod  <= 64'(folded) * 64'(RECIP);
          state <= F_MUL2;
        end
        F_MUL2: begin
          qb    <= 31'(prod[62:32] * 31'(BMUL));
          state <= F_SEND;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ src/hml_queue.sv @@
`timescale 1ns / 1ps
module hml_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  hml_pkg::job_t wr_job,
  output logic          space,
  output logic          avail,
  input  logic          rd_en,
  output hml_pkg::job_t rd_job
);
  import hml_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign space  = (count != 2'd2);
  assign avail  = (count != 2'd0);
  assign rd_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en && space) begin
        slots[wr_ptr] <= wr_job;
        wr_ptr        <= ~wr_ptr;
      end
      if (rd_en && avail) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'((wr_en && space) ? 1 : 0) - 2'((rd_en && avail) ? 1 : 0);
    end
  end

endmodule

@@ src/hml_back.sv @@
`timescale 1ns / 1ps
module hml_back #(
  parameter int BUCKETS  = 1024,
  parameter int CAPACITY = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_avail,
  input  hml_pkg::job_t job,
  output logic          job_take,
  output logic          rsp_valid,
  input  logic          rsp_take,
  output hml_pkg::rsp_t rsp
);
  import hml_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] CAP = PW'(CAPACITY);
  localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_HEAD, B_TEST, B_CMP} bstate_t;

  bstate_t     state;
  logic [BW-1:0] clr_idx;
  logic [PW-1:0] pool_fill;
  logic [PW-1:0] cur;
  logic [PW-1:0] steps;
  logic [31:0]   it_key;
  logic [7:0]    it_val;
  logic [BW-1:0] it_bucket;

  logic [PW-1:0] heads [BUCKETS];
  logic [31:0]   ekeys [CAPACITY];
  logic [7:0]    evals [CAPACITY];
  logic [PW-1:0] elinks [CAPACITY];

  logic [PW-1:0] head_rd;
  logic [31:0]   key_rd;
  logic [7:0]    val_rd;
  logic [PW-1:0] link_rd;

  logic          walk;
  logic          ins;
  logic          head_we;
  logic [BW-1:0] head_wa;
  logic [PW-1:0] head_wd;
  logic [BW-1:0] head_ra;
  logic [PW-1:0] cur_m1;
  logic [EW-1:0] fill_idx;

  assign job_take = (state == B_IDLE) && job_avail && !rsp_valid;
  assign walk     = (cur != '0) && (cur <= CAP) && (steps < pool_fill);
  assign ins      = (state == B_TEST) && !walk && (it_val != 8'd0) && (pool_fill < CAP);
  assign cur_m1   = cur - PW'(1);
  assign fill_idx = pool_fill[EW-1:0];

  // read the incoming word's bucket while idle, then keep reading the current one
  assign head_ra  = (state == B_IDLE) ? job.bucket[BW-1:0] : it_bucket;

  always_comb begin
    head_we = (state == B_CLEAR) || ins;
    head_wa = (state == B_CLEAR) ? clr_idx : it_bucket;
    head_wd = (state == B_CLEAR) ? '0 : (pool_fill + PW'(1));
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_wa] <= head_wd;
    end
    head_rd <= heads[head_ra];
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      ekeys[fill_idx]  <= it_key;
      evals[fill_idx]  <= it_val;
      elinks[fill_idx] <= head_rd;
    end
    key_rd  <= ekeys[cur_m1[EW-1:0]];
    val_rd  <= evals[cur_m1[EW-1:0]];
    link_rd <= elinks[cur_m1[EW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      clr_idx   <= '0;
      pool_fill <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_take) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        B_CLEAR: begin
          clr_idx <= clr_idx + BW'(1);
          if (clr_idx == LAST_BUCKET) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (job_take) begin
            it_key    <= job.key;
            it_val    <= job.insert_value;
            it_bucket <= job.bucket[BW-1:0];
            if (job.opcode == OP_CLEAR) begin
              pool_fill  <= '0;
              clr_idx    <= '0;
              rsp_valid  <= 1'b1;
              rsp.answer <= 8'd0;
              rsp.status <= ST_CLEARED;
              state      <= B_CLEAR;
            end else begin
              state <= B_HEAD;
            end
          end
        end
        B_HEAD: begin
          cur   <= head_rd;
          steps <= '0;
          state <= B_TEST;
        end
        B_TEST: begin
          if (walk) begin
            state <= B_CMP;
          end else begin
            rsp_valid  <= 1'b1;
            rsp.answer <= 8'd0;
            state      <= B_IDLE;
            if (it_val == 8'd0) begin
              rsp.status <= ST_NOTFOUND;
            end else if (pool_fill >= CAP) begin
              rsp.status <= ST_FULL;
            end else begin
              rsp.status <= ST_INSERTED;
              pool_fill  <= pool_fill + PW'(1);
            end
          end
        end
        B_CMP: begin
          if (key_rd == it_key) begin
            rsp_valid  <= 1'b1;
            rsp.answer <= val_rd;
            rsp.status <= ST_FOUND;
            state      <= B_IDLE;
          end else begin
            cur   <= link_rd;
            steps <= steps + PW'(1);
            state <= B_TEST;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ src/hash_map_lookup_insert.sv @@
`timescale 1ns / 1ps
// The front folds the key and reduces it to a bucket (F_MUL, F_MUL2, then F_SEND), the
// queue buffers the word, and the back reads the bucket head (B_HEAD), then tests and
// compares each chain entry in turn (B_TEST, B_CMP) until a match or the chain's end.
// The back takes a new word only once the previous result has been popped;
// a clear word holds the back while it sweeps the bucket heads.
// Reset (rst, synchronous): a sweep over all BUCKETS heads empties them first.
module hash_map_lookup_insert #(
  parameter int BUCKETS  = 1024,
  parameter int CAPACITY = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  hml_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output hml_pkg::rsp_t rsp
);
  import hml_pkg::*;

  // front to queue
  logic job_valid;
  logic job_space;
  job_t job_in;

  // queue to back
  logic job_avail;
  logic job_take;
  job_t job_out;

  logic rsp_valid;

  // fold and bucket reduction; holds one word until the queue has room
  hml_front #(.BUCKETS(BUCKETS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .job_valid (job_valid),
    .job_space (job_space),
    .job       (job_in)
  );

  // two-word decoupling queue: the front keeps working while the back walks a chain
  hml_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (job_in),
    .space  (job_space),
    .avail  (job_avail),
    .rd_en  (job_take),
    .rd_job (job_out)
  );

  // chain walk, insert and clear sweep; result register drives the output side
  hml_back #(.BUCKETS(BUCKETS), .CAPACITY(CAPACITY)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_avail (job_avail),
    .job       (job_out),
    .job_take  (job_take),
    .rsp_valid (rsp_valid),
    .rsp_take  (pop),
    .rsp       (rsp)
  );

  assign empty = !rsp_valid;

`ifndef ASSERT_OFF
  // the back never takes a word from an empty queue
  a_take_avail : assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_avail)
    else $error("back took a word from an empty queue");

  // a new result is never loaded over one that is still waiting
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("pending result dropped");

  // status code on a waiting result stays within the defined codes
  a_status_legal : assert property (@(posedge clk) disable iff (rst)
    !empty |-> (rsp.status <= ST_CLEARED))
    else $error("undefined status code");

  // the back takes a word only while its result register is free
  a_take_free : assert property (@(posedge clk) disable iff (rst)
    job_take |-> empty)
    else $error("word taken while a result waits");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import hml_pkg::*;

  localparam int BUCKETS  = 1024;
  localparam int CAPACITY = 4096;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  push = 1'b0;
  logic  full;
  req_t  req = '0;
  logic  empty;
  logic  pop = 1'b0;
  rsp_t  rsp;

  hash_map_lookup_insert #(
    .BUCKETS(BUCKETS),
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the table. Chain links and heads hold entry index + 1, 0 = none.
  int unsigned  head_of[BUCKETS];
  logic [31:0]  slot_key[CAPACITY];
  logic [7:0]   slot_val[CAPACITY];
  int unsigned  slot_next[CAPACITY];
  int unsigned  slots_used;

  rsp_t exp_q[$];
  int   errors = 0;
  int   tx_idle = 0;   // percent of cycles the sender holds off
  int   rx_idle = 0;   // percent of cycles the receiver stalls
  logic [31:0] hot_keys[64];

  function automatic void wipe_table();
    foreach (head_of[i]) head_of[i] = 0;
    slots_used = 0;
  endfunction

  // Work out the answer to one accepted word and update the shadow table.
  function automatic rsp_t lookup_or_insert(req_t r);
    rsp_t        o;
    logic [31:0] k;
    logic [31:0] folded;
    int unsigned b, cur, steps;
    o.answer = '0;
    if (r.opcode == OP_CLEAR) begin
      wipe_table();
      o.status = ST_CLEARED;
      return o;
    end
    k      = r.key;
    folded = k[31] ? ~k : k;
    b      = folded % BUCKETS;
    cur    = head_of[b];
    steps  = 0;
    // walk the chain, bounded by the number of entries in use
    while (cur != 0 && cur <= CAPACITY && steps < slots_used) begin
      if (slot_key[cur-1] == k) begin
        o.answer = slot_val[cur-1];
        o.status = ST_FOUND;
        return o;
      end
      cur = slot_next[cur-1];
      steps++;
    end
    if (r.insert_value == 8'd0) o.status = ST_NOTFOUND;
    else if (slots_used >= CAPACITY) o.status = ST_FULL;
    else begin
      slot_key[slots_used]  = k;
      slot_val[slots_used]  = r.insert_value;
      slot_next[slots_used] = head_of[b];
      head_of[b]            = slots_used + 1;
      slots_used++;
      o.status = ST_INSERTED;
    end
    return o;
  endfunction

  // Offer one word, hold it until taken, then record what must come back.
  task automatic send_word(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    while ($urandom_range(99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req  <= r;
    do @(posedge clk); while (full);
    predicted = lookup_or_insert(r);
    exp_q.push_back(typed ? typed_rsp : predicted);
  endtask

  function automatic req_t random_word();
    req_t r;
    int   pick;
    pick = $urandom_range(99);
    r.opcode = (pick == 0) ? OP_CLEAR : OP_LOOKUP;
    pick = $urandom_range(99);
    // mostly reuse a small key set so lookups hit; fold partners share a bucket
    if (pick < 55) r.key = hot_keys[$urandom_range(63)];
    else if (pick < 70) r.key = ~hot_keys[$urandom_range(63)];
    else r.key = $urandom;
    r.insert_value = ($urandom_range(1)) ? 8'($urandom) : 8'd0;
    return r;
  endfunction

  // Check each popped word against the oldest expectation, then pick the next pop.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected word answer=%0d status=%0d", $time, rsp.answer, rsp.status);
        errors++;
      end else begin
        if (rsp.answer !== exp_q[0].answer) begin
          $display("%0t: answer expected %0d actual %0d", $time, exp_q[0].answer, rsp.answer);
          errors++;
        end
        if (rsp.status !== exp_q[0].status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_q[0].status, rsp.status);
          errors++;
        end
        void'(exp_q.pop_front());
      end
    end
    pop <= ($urandom_range(99) >= rx_idle);
  end

  typedef struct {
    logic        op;
    logic [31:0] key;
    logic [7:0]  val;
    bit          typed;
    logic [7:0]  ans;
    logic [2:0]  st;
  } row_t;

  row_t rows[$] = '{
    '{OP_LOOKUP, 32'h0000_0000, 8'd0,   1, 8'd0,   ST_NOTFOUND},
    '{OP_LOOKUP, 32'h0000_0000, 8'd255, 1, 8'd0,   ST_INSERTED},
    '{OP_LOOKUP, 32'h0000_0000, 8'd0,   1, 8'd255, ST_FOUND},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 8'd1,   1, 8'd0,   ST_INSERTED},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 8'd0,   1, 8'd1,   ST_FOUND},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 8'd128, 1, 8'd0,   ST_INSERTED},
    '{OP_LOOKUP, 32'h8000_0000, 8'd0,   1, 8'd0,   ST_NOTFOUND},
    '{OP_LOOKUP, 32'h8000_0000, 8'd7,   1, 8'd0,   ST_INSERTED},
    '{OP_LOOKUP, 32'h8000_0000, 8'd0,   1, 8'd7,   ST_FOUND},
    '{OP_LOOKUP, 32'h0000_0400, 8'd3,   1, 8'd0,   ST_INSERTED},
    '{OP_LOOKUP, 32'h0000_0000, 8'd9,   1, 8'd255, ST_FOUND},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 8'd0,   0, 8'd0,   ST_FOUND},
    '{OP_LOOKUP, 32'hAAAA_5555, 8'hAA,  0, 8'd0,   ST_FOUND},
    '{OP_LOOKUP, 32'h5555_AAAA, 8'h55,  0, 8'd0,   ST_FOUND},
    '{OP_LOOKUP, 32'hAAAA_5555, 8'd0,   0, 8'd0,   ST_FOUND},
    '{OP_CLEAR,  32'h1234_5678, 8'd77,  1, 8'd0,   ST_CLEARED},
    '{OP_LOOKUP, 32'h0000_0000, 8'd0,   1, 8'd0,   ST_NOTFOUND},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 8'd0,   1, 8'd0,   ST_NOTFOUND},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 8'd200, 1, 8'd0,   ST_INSERTED}
  };

  initial begin
    req_t r;
    rsp_t e;
    wipe_table();
    foreach (hot_keys[i]) hot_keys[i] = $urandom;
    hot_keys[0] = 32'h0;
    hot_keys[1] = 32'h8000_0000;
    hot_keys[2] = 32'h7FFF_FFFF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (rows[i]) begin
      r = '{opcode: rows[i].op, key: rows[i].key, insert_value: rows[i].val};
      e = '{answer: rows[i].ans, status: rows[i].st};
      send_word(r, rows[i].typed, e);
    end

    // random, sender barely idles and receiver mostly stalls
    tx_idle = 8; rx_idle = 85;
    repeat (400) send_word(random_word(), 0, '0);

    // random, the other way round
    tx_idle = 85; rx_idle = 8;
    repeat (400) send_word(random_word(), 0, '0);

    // no idling: clear, load a run of fresh keys, then random words around a second clear
    tx_idle = 0; rx_idle = 0;
    send_word('{opcode: OP_CLEAR, key: 32'h0, insert_value: 8'h0}, 0, '0);
    for (int i = 0; i < 300; i++) begin
      r.opcode       = OP_LOOKUP;
      r.key          = 32'(i * 977) ^ (i[0] ? 32'hFFFF_0000 : 32'h0);
      r.insert_value = 8'($urandom_range(255, 1));
      send_word(r, 0, '0);
    end
    repeat (150) send_word(random_word(), 0, '0);
    send_word('{opcode: OP_CLEAR, key: 32'h0, insert_value: 8'h0}, 0, '0);
    repeat (30) send_word(random_word(), 0, '0);
    push <= 1'b0;

    // drain, then give the back end time to spit out anything stray
    while (exp_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ hash_map_lookup_insert.f @@
src/hml_pkg.sv
src/hml_front.sv
src/hml_queue.sv
src/hml_back.sv
src/hash_map_lookup_insert.sv
tb/tb_top.sv
